// File: design/ccfr_pkg.sv
// ----------------------------------------------------------------------------
// ccfr_pkg
// Shared constants, status codes and the CRC-16/CCITT-FALSE byte update for
// the COBS frame receiver.
// ----------------------------------------------------------------------------
package ccfr_pkg;

   localparam int FRAME_LIMIT_MAX = 1024;
   localparam int COUNT_W         = $clog2(FRAME_LIMIT_MAX + 1);
   localparam int CFG_W           = 11;
   localparam int LEN_W           = 11;
   localparam int LIMIT_W         = (COUNT_W > CFG_W) ? COUNT_W : CFG_W;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;

   localparam logic [CFG_W-1:0]   CFG_RESET    = CFG_W'(1024);
   localparam logic [15:0]        CRC_INIT     = 16'hFFFF;
   localparam logic [15:0]        CRC_POLY     = 16'h1021;
   localparam logic [7:0]         CODE_FULL    = 8'hFF;
   localparam logic [7:0]         DELIM_BYTE   = 8'h00;
   localparam logic [COUNT_W-1:0] DELAY_BYTES  = COUNT_W'(2);
   localparam logic [COUNT_W-1:0] MIN_DECODED  = COUNT_W'(3);

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_CRC      = 2'd1,
      STATUS_SHORT    = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: design/ccfr_csr.sv
// ----------------------------------------------------------------------------
// ccfr_csr
// Configuration register block: holds the per-frame raw byte limit behind a
// simple APB-style register port.
// ----------------------------------------------------------------------------
module ccfr_csr
   import ccfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [CFG_W-1:0]      max_frame_bytes
);

   logic [CFG_W-1:0] max_frame_ff;
   logic [CFG_W-1:0] max_frame_in;
   logic             sel_limit;

   assign sel_limit  = (csr_paddr[CSR_ADDR_W-1] == 1'b0);
   assign csr_pready = 1'b1;

   always_comb begin
      max_frame_in = max_frame_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_limit) begin
         max_frame_in = csr_pwdata[CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_ff <= CFG_RESET;
      end else begin
         max_frame_ff <= max_frame_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (sel_limit) begin
         csr_prdata = CSR_DATA_W'(max_frame_ff);
      end
   end

   assign max_frame_bytes = max_frame_ff;

endmodule

// File: design/cobs_crc_frame_receiver.sv
// ----------------------------------------------------------------------------
// cobs_crc_frame_receiver
// COBS deframer with CRC-16/CCITT-FALSE check: decodes raw link bytes into
// payload bytes and gives one end transaction with status per frame.
// ----------------------------------------------------------------------------
// A byte passes from the input register into the result register, and waits
// in the input register while a result is stalled at the output.
// Throughput: one byte per cycle while the output is not stalled.
// Reset is synchronous and active high; the limit returns to 1024 bytes and
// the frame state restarts. No clearing pass is needed after reset.
module cobs_crc_frame_receiver
   import ccfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_raw_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_payload_byte,
   output logic                  rsp_frame_end,
   output logic [1:0]            rsp_frame_status,
   output logic [LEN_W-1:0]      rsp_payload_length,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [CFG_W-1:0]   max_frame_bytes;
   logic [LIMIT_W-1:0] limit;

   logic               advance;
   logic               load_s1;
   logic               process;

   logic               s1_valid_ff, s1_valid_in;
   logic [7:0]         s1_byte_ff, s1_byte_in;

   logic [7:0]         block_left_ff, block_left_in;
   logic               zero_owed_ff, zero_owed_in;
   logic [COUNT_W-1:0] raw_count_ff, raw_count_in;
   logic [COUNT_W-1:0] dec_count_ff, dec_count_in;
   logic [7:0]         tail0_ff, tail0_in;
   logic [7:0]         tail1_ff, tail1_in;
   logic [15:0]        crc_ff, crc_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic               rsp_end_ff, rsp_end_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]   rsp_len_ff, rsp_len_in;

   logic               emit;
   logic               do_deliver;
   logic [7:0]         deliver_byte;
   logic               restart;
   logic               have_payload;
   logic [COUNT_W-1:0] payload_given;
   logic [15:0]        crc_next;

   ccfr_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .max_frame_bytes (max_frame_bytes)
   );

   assign limit = (LIMIT_W'(max_frame_bytes) > LIMIT_W'(FRAME_LIMIT_MAX)) ?
                  LIMIT_W'(FRAME_LIMIT_MAX) : LIMIT_W'(max_frame_bytes);

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign load_s1   = !s1_valid_ff || advance;
   assign process   = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (load_s1) begin
         s1_valid_in = req_valid;
         if (req_valid) begin
            s1_byte_in = req_raw_byte;
         end
      end
   end

   assign have_payload  = (dec_count_ff >= DELAY_BYTES);
   assign payload_given = have_payload ? (dec_count_ff - DELAY_BYTES) : '0;
   assign crc_next      = crc16_byte(crc_ff, tail0_ff);

   always_comb begin
      emit          = 1'b0;
      restart       = 1'b0;
      do_deliver    = 1'b0;
      deliver_byte  = DELIM_BYTE;
      rsp_byte_in   = 8'h00;
      rsp_end_in    = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_len_in    = '0;
      block_left_in = block_left_ff;
      zero_owed_in  = zero_owed_ff;
      raw_count_in  = raw_count_ff;
      dec_count_in  = dec_count_ff;
      tail0_in      = tail0_ff;
      tail1_in      = tail1_ff;
      crc_in        = crc_ff;

      if (process) begin
         if (s1_byte_ff == DELIM_BYTE) begin
            if (raw_count_ff != '0) begin
               emit       = 1'b1;
               restart    = 1'b1;
               rsp_end_in = 1'b1;
               rsp_len_in = LEN_W'(payload_given);
               if (dec_count_ff < MIN_DECODED) begin
                  rsp_status_in = STATUS_SHORT;
               end else if ({tail0_ff, tail1_ff} == crc_ff) begin
                  rsp_status_in = STATUS_OK;
               end else begin
                  rsp_status_in = STATUS_CRC;
               end
            end
         end else if (LIMIT_W'(raw_count_ff) >= limit) begin
            emit          = 1'b1;
            restart       = 1'b1;
            rsp_end_in    = 1'b1;
            rsp_status_in = STATUS_OVERFLOW;
            rsp_len_in    = LEN_W'(payload_given);
         end else begin
            raw_count_in = raw_count_ff + COUNT_W'(1);
            if (block_left_ff == 8'h00) begin
               do_deliver    = zero_owed_ff;
               deliver_byte  = DELIM_BYTE;
               block_left_in = s1_byte_ff - 8'd1;
               zero_owed_in  = (s1_byte_ff != CODE_FULL);
            end else begin
               do_deliver    = 1'b1;
               deliver_byte  = s1_byte_ff;
               block_left_in = block_left_ff - 8'd1;
            end
         end

         if (do_deliver) begin
            if (have_payload) begin
               emit        = 1'b1;
               rsp_byte_in = tail0_ff;
               crc_in      = crc_next;
            end
            tail0_in     = tail1_ff;
            tail1_in     = deliver_byte;
            dec_count_in = dec_count_ff + COUNT_W'(1);
         end

         if (restart) begin
            block_left_in = 8'h00;
            zero_owed_in  = 1'b0;
            raw_count_in  = '0;
            dec_count_in  = '0;
            tail0_in      = 8'h00;
            tail1_in      = 8'h00;
            crc_in        = CRC_INIT;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = process && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         block_left_ff <= 8'h00;
         zero_owed_ff  <= 1'b0;
         raw_count_ff  <= '0;
         dec_count_ff  <= '0;
         tail0_ff      <= 8'h00;
         tail1_ff      <= 8'h00;
         crc_ff        <= CRC_INIT;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         block_left_ff <= block_left_in;
         zero_owed_ff  <= zero_owed_in;
         raw_count_ff  <= raw_count_in;
         dec_count_ff  <= dec_count_in;
         tail0_ff      <= tail0_in;
         tail1_ff      <= tail1_in;
         crc_ff        <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      if (advance) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_end_ff    <= rsp_end_in;
         rsp_status_ff <= rsp_status_in;
         rsp_len_ff    <= rsp_len_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_byte   = rsp_byte_ff;
   assign rsp_frame_end      = rsp_end_ff;
   assign rsp_frame_status   = rsp_status_ff;
   assign rsp_payload_length = rsp_len_ff;

   // The decoder never produces more bytes than it has received.
   assert property (@(posedge clock) disable iff (reset)
      dec_count_ff <= raw_count_ff)
      else $error("decoded byte count exceeds raw byte count");

   // Ending a frame always returns the frame state to its starting values.
   assert property (@(posedge clock) disable iff (reset)
      (process && restart) |=> (raw_count_ff == '0 && dec_count_ff == '0 &&
                                crc_ff == CRC_INIT && !zero_owed_ff))
      else $error("frame state not restarted after end transaction");

   // A payload transaction carries no status and no length.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_end_ff) |-> (rsp_status_ff == STATUS_OK && rsp_len_ff == '0))
      else $error("payload transaction carries end fields");

   // The input side is only held back while the input register is occupied.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("input stalled without a waiting transaction");

   // A result leaves the pipeline only from a byte that was being processed.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result produced without an input transaction");

endmodule
